>>> design/tsagg_pkg.sv
// Shared types, constants and helpers for the block timestamp aggregator.
`timescale 1ns / 1ps

package tsagg_pkg;

    localparam int STAMP_BITS = 62;
    localparam int COUNT_BITS = 32;
    localparam int MODE_BITS  = 3;
    localparam int CNT_W      = $clog2(STAMP_BITS);

    typedef enum logic [1:0] {
        KIND_NORMAL = 2'd0,
        KIND_NAT    = 2'd1,
        KIND_PINF   = 2'd2,
        KIND_NINF   = 2'd3
    } kind_t;

    localparam logic [MODE_BITS-1:0] MODE_FIRST  = 3'd0;
    localparam logic [MODE_BITS-1:0] MODE_LAST   = 3'd1;
    localparam logic [MODE_BITS-1:0] MODE_MAX    = 3'd2;
    localparam logic [MODE_BITS-1:0] MODE_MEAN   = 3'd3;
    localparam logic [MODE_BITS-1:0] MODE_MIDDLE = 3'd4;
    localparam logic [MODE_BITS-1:0] MODE_MIN    = 3'd5;

    localparam logic [COUNT_BITS-1:0] MID_DIVISOR = COUNT_BITS'(2);

    typedef logic [STAMP_BITS-1:0] stamp_t;
    typedef logic [COUNT_BITS-1:0] count_t;

    // status of the serial difference unit
    typedef struct packed {
        logic done;
        logic a_lt_b;
        logic b_lt_a;
    } diff_stat_t;

    // minus infinity < normal < plus infinity; not-a-time ranks with normal
    function automatic logic [1:0] kind_rank(input kind_t k);
        logic [1:0] r;
        case (k)
            KIND_NINF: r = 2'd0;
            KIND_PINF: r = 2'd2;
            default:   r = 2'd1;
        endcase
        return r;
    endfunction

endpackage

>>> design/tsagg_if.sv
// Stream and configuration channel interfaces of the aggregator.
`timescale 1ns / 1ps

interface tsagg_point_if import tsagg_pkg::*; ();
    logic   valid;
    logic   ready;
    stamp_t stamp;
    logic [1:0] stamp_kind;
    logic   last_of_block;

    modport source (output valid, output stamp, output stamp_kind,
                    output last_of_block, input ready);
    modport sink   (input valid, input stamp, input stamp_kind,
                    input last_of_block, output ready);
endinterface

interface tsagg_block_if import tsagg_pkg::*; ();
    logic   valid;
    logic   ready;
    stamp_t block_stamp;
    logic [1:0] block_kind;

    modport source (output valid, output block_stamp, output block_kind, input ready);
    modport sink   (input valid, input block_stamp, input block_kind, output ready);
endinterface

interface tsagg_cfg_if import tsagg_pkg::*; ();
    logic valid;
    logic ready;
    logic [MODE_BITS-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> design/tsagg_diff.sv
// Bit-serial subtractor: forms a-b and b-a LSB first, one bit per cycle.
`timescale 1ns / 1ps

module tsagg_diff import tsagg_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  stamp_t     a,
    input  stamp_t     b,
    output diff_stat_t stat,
    output stamp_t     mag
);

    stamp_t           a_reg, a_next;
    stamp_t           b_reg, b_next;
    logic             bor_ab_reg, bor_ab_next;
    logic             bor_ba_reg, bor_ba_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;

    logic d_ab, d_ba;

    always_comb
    begin
        a_next      = a_reg;
        b_next      = b_reg;
        bor_ab_next = bor_ab_reg;
        bor_ba_next = bor_ba_reg;
        cnt_next    = cnt_reg;
        busy_next   = busy_reg;
        done_next   = 1'b0;

        d_ab = a_reg[0] ^ b_reg[0] ^ bor_ab_reg;
        d_ba = a_reg[0] ^ b_reg[0] ^ bor_ba_reg;

        if (start)
        begin
            a_next      = a;
            b_next      = b;
            bor_ab_next = 1'b0;
            bor_ba_next = 1'b0;
            cnt_next    = '0;
            busy_next   = 1'b1;
        end
        else if (busy_reg)
        begin
            // difference bits shift in at the top as operand bits leave
            a_next      = {d_ab, a_reg[STAMP_BITS-1:1]};
            b_next      = {d_ba, b_reg[STAMP_BITS-1:1]};
            bor_ab_next = (~a_reg[0] & b_reg[0]) | (~(a_reg[0] ^ b_reg[0]) & bor_ab_reg);
            bor_ba_next = (~b_reg[0] & a_reg[0]) | (~(a_reg[0] ^ b_reg[0]) & bor_ba_reg);
            cnt_next    = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(STAMP_BITS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg      <= a_next;
        b_reg      <= b_next;
        bor_ab_reg <= bor_ab_next;
        bor_ba_reg <= bor_ba_next;
    end

    // final borrow of a-b set means a < b
    assign stat.done   = done_reg;
    assign stat.a_lt_b = bor_ab_reg;
    assign stat.b_lt_a = bor_ba_reg;
    assign mag         = bor_ab_reg ? b_reg : a_reg;

endmodule

>>> design/tsagg_div.sv
// Radix-2 restoring divider, one quotient bit per cycle, MSB first.
`timescale 1ns / 1ps

module tsagg_div import tsagg_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   start,
    input  stamp_t dividend,
    input  count_t divisor,
    output logic   done,
    output stamp_t quotient
);

    stamp_t           q_reg, q_next;
    count_t           r_reg, r_next;
    count_t           dvs_reg, dvs_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;

    logic [COUNT_BITS:0] trial;
    logic [COUNT_BITS:0] trial_sub;
    logic                ge;

    always_comb
    begin
        q_next    = q_reg;
        r_next    = r_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;

        trial     = {r_reg, q_reg[STAMP_BITS-1]};
        trial_sub = trial - {1'b0, dvs_reg};
        ge        = trial >= {1'b0, dvs_reg};

        if (start)
        begin
            q_next    = dividend;
            r_next    = '0;
            dvs_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // dividend bits leave at the top, quotient bits enter at the bottom
            q_next   = {q_reg[STAMP_BITS-2:0], ge};
            r_next   = ge ? trial_sub[COUNT_BITS-1:0] : trial[COUNT_BITS-1:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(STAMP_BITS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        r_reg   <= r_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

>>> design/block_timestamp_aggregator_core.sv
// Top level: block timestamp aggregator with bit-serial arithmetic.
//
//  channel  | dir | handshake     | payload
//  points   | in  | valid / ready | stamp, stamp_kind, last_of_block
//  blocks   | out | valid / ready | block_stamp, block_kind
//  cfg      | in  | valid / ready | data (mode)
//
// One point at a time; a point that needs no arithmetic passes S_EVAL, S_FIN.
// Max/min between two normal stamps adds a serial compare in S_DIFF.
// Mean and middle run serial subtract, a 62-step divider and a serial add;
// the divider and the serial passes set the time per point.
// Reset clears all held state and the mode. While a result waits on a stalled
// blocks channel, the next point that ends a block stalls the core in S_FIN.
`timescale 1ns / 1ps

module block_timestamp_aggregator_core import tsagg_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    tsagg_point_if.sink   points,
    tsagg_block_if.source blocks,
    tsagg_cfg_if.sink     cfg
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_EVAL = 6'b000010,
        S_DIFF = 6'b000100,
        S_DIV  = 6'b001000,
        S_ADD  = 6'b010000,
        S_FIN  = 6'b100000
    } state_t;

    state_t               state_reg, state_next;
    logic [MODE_BITS-1:0] mode_reg, mode_next;

    stamp_t held_stamp_reg, held_stamp_next;
    kind_t  held_kind_reg, held_kind_next;
    logic   held_valid_reg, held_valid_next;
    count_t count_reg, count_next;

    stamp_t pt_stamp_reg, pt_stamp_next;
    kind_t  pt_kind_reg, pt_kind_next;
    logic   pt_last_reg, pt_last_next;

    stamp_t           q_reg, q_next;
    logic             carry_reg, carry_next;
    logic [CNT_W-1:0] add_cnt_reg, add_cnt_next;

    logic   out_valid_reg, out_valid_next;
    stamp_t out_stamp_reg, out_stamp_next;
    kind_t  out_kind_reg, out_kind_next;

    logic       diff_start;
    diff_stat_t diff_stat;
    stamp_t     diff_mag;
    logic       div_start;
    logic       div_done;
    stamp_t     div_quot;
    count_t     div_divisor;

    logic [MODE_BITS-1:0] eff_mode;
    logic [1:0]           rank_h, rank_s;
    logic                 add_b, sum_bit;

    tsagg_diff u_diff (
        .clk   (clk),
        .rst_n (rst_n),
        .start (diff_start),
        .a     (pt_stamp_reg),
        .b     (held_stamp_reg),
        .stat  (diff_stat),
        .mag   (diff_mag)
    );

    tsagg_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (diff_mag),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quot)
    );

    assign points.ready       = (state_reg == S_IDLE);
    assign cfg.ready          = 1'b1;
    assign blocks.valid       = out_valid_reg;
    assign blocks.block_stamp = out_stamp_reg;
    assign blocks.block_kind  = out_kind_reg;

    assign div_divisor = (eff_mode == MODE_MEAN) ? count_reg : MID_DIVISOR;

    always_comb
    begin
        case (mode_reg)
            MODE_LAST, MODE_MAX, MODE_MEAN, MODE_MIDDLE, MODE_MIN: eff_mode = mode_reg;
            default:                                                eff_mode = MODE_FIRST;
        endcase
    end

    always_comb
    begin
        state_next      = state_reg;
        mode_next       = mode_reg;
        held_stamp_next = held_stamp_reg;
        held_kind_next  = held_kind_reg;
        held_valid_next = held_valid_reg;
        count_next      = count_reg;
        pt_stamp_next   = pt_stamp_reg;
        pt_kind_next    = pt_kind_reg;
        pt_last_next    = pt_last_reg;
        q_next          = q_reg;
        carry_next      = carry_reg;
        add_cnt_next    = add_cnt_reg;
        out_valid_next  = out_valid_reg;
        out_stamp_next  = out_stamp_reg;
        out_kind_next   = out_kind_reg;
        diff_start      = 1'b0;
        div_start       = 1'b0;

        rank_h  = kind_rank(held_kind_reg);
        rank_s  = kind_rank(pt_kind_reg);
        // subtract when the stamp went down: held + ~q + 1
        add_b   = q_reg[0] ^ diff_stat.a_lt_b;
        sum_bit = held_stamp_reg[0] ^ add_b ^ carry_reg;

        if (cfg.valid)
        begin
            mode_next = cfg.data;
        end

        if (out_valid_reg && blocks.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (points.valid)
                begin
                    pt_stamp_next = points.stamp;
                    pt_kind_next  = kind_t'(points.stamp_kind);
                    pt_last_next  = points.last_of_block;
                    state_next    = S_EVAL;
                end
            end

            S_EVAL:
            begin
                state_next = S_FIN;
                case (eff_mode)
                    MODE_LAST:
                    begin
                        if (pt_last_reg)
                        begin
                            held_stamp_next = (pt_kind_reg == KIND_NORMAL) ? pt_stamp_reg : '0;
                            held_kind_next  = pt_kind_reg;
                            held_valid_next = 1'b1;
                        end
                    end

                    MODE_MAX, MODE_MIN:
                    begin
                        if (!held_valid_reg)
                        begin
                            held_stamp_next = (pt_kind_reg == KIND_NORMAL) ? pt_stamp_reg : '0;
                            held_kind_next  = pt_kind_reg;
                            held_valid_next = 1'b1;
                        end
                        else if (held_kind_reg == KIND_NAT)
                        begin
                            // not-a-time sticks for the rest of the block
                        end
                        else if (pt_kind_reg == KIND_NAT)
                        begin
                            held_stamp_next = '0;
                            held_kind_next  = KIND_NAT;
                        end
                        else if (rank_h != rank_s)
                        begin
                            if ((eff_mode == MODE_MAX) ? (rank_h < rank_s) : (rank_s < rank_h))
                            begin
                                held_stamp_next = (pt_kind_reg == KIND_NORMAL) ?
                                                  pt_stamp_reg : '0;
                                held_kind_next  = pt_kind_reg;
                            end
                        end
                        else if (pt_kind_reg == KIND_NORMAL)
                        begin
                            diff_start = 1'b1;
                            state_next = S_DIFF;
                        end
                    end

                    MODE_MEAN:
                    begin
                        if (pt_kind_reg != KIND_NORMAL)
                        begin
                            // special stamps are skipped
                        end
                        else if (!held_valid_reg)
                        begin
                            held_stamp_next = pt_stamp_reg;
                            held_kind_next  = KIND_NORMAL;
                            held_valid_next = 1'b1;
                            count_next      = COUNT_BITS'(1);
                        end
                        else if (held_kind_reg == KIND_NORMAL)
                        begin
                            if (count_reg != {COUNT_BITS{1'b1}})
                            begin
                                count_next = count_reg + 1'b1;
                            end
                            diff_start = 1'b1;
                            state_next = S_DIFF;
                        end
                    end

                    MODE_MIDDLE:
                    begin
                        if (!held_valid_reg)
                        begin
                            held_valid_next = 1'b1;
                            if (pt_last_reg && pt_kind_reg != KIND_NORMAL)
                            begin
                                held_stamp_next = '0;
                                held_kind_next  = KIND_NAT;
                            end
                            else
                            begin
                                held_stamp_next = (pt_kind_reg == KIND_NORMAL) ?
                                                  pt_stamp_reg : '0;
                                held_kind_next  = pt_kind_reg;
                            end
                        end
                        else if (pt_last_reg)
                        begin
                            if (pt_kind_reg != KIND_NORMAL || held_kind_reg != KIND_NORMAL)
                            begin
                                held_stamp_next = '0;
                                held_kind_next  = KIND_NAT;
                            end
                            else
                            begin
                                diff_start = 1'b1;
                                state_next = S_DIFF;
                            end
                        end
                    end

                    default:
                    begin
                        if (!held_valid_reg)
                        begin
                            held_stamp_next = (pt_kind_reg == KIND_NORMAL) ? pt_stamp_reg : '0;
                            held_kind_next  = pt_kind_reg;
                            held_valid_next = 1'b1;
                        end
                    end
                endcase
            end

            S_DIFF:
            begin
                if (diff_stat.done)
                begin
                    if (eff_mode == MODE_MEAN || eff_mode == MODE_MIDDLE)
                    begin
                        div_start  = 1'b1;
                        state_next = S_DIV;
                    end
                    else
                    begin
                        // a is the new stamp, b the held one
                        if ((eff_mode == MODE_MAX) ? diff_stat.b_lt_a : diff_stat.a_lt_b)
                        begin
                            held_stamp_next = pt_stamp_reg;
                            held_kind_next  = KIND_NORMAL;
                        end
                        state_next = S_FIN;
                    end
                end
            end

            S_DIV:
            begin
                if (div_done)
                begin
                    q_next       = div_quot;
                    carry_next   = diff_stat.a_lt_b;
                    add_cnt_next = '0;
                    state_next   = S_ADD;
                end
            end

            S_ADD:
            begin
                held_stamp_next = {sum_bit, held_stamp_reg[STAMP_BITS-1:1]};
                q_next          = {1'b0, q_reg[STAMP_BITS-1:1]};
                carry_next      = (held_stamp_reg[0] & add_b) |
                                  (carry_reg & (held_stamp_reg[0] ^ add_b));
                add_cnt_next    = add_cnt_reg + 1'b1;
                if (add_cnt_reg == CNT_W'(STAMP_BITS - 1))
                begin
                    state_next = S_FIN;
                end
            end

            S_FIN:
            begin
                if (!pt_last_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (!out_valid_reg || blocks.ready)
                begin
                    out_valid_next  = 1'b1;
                    if (held_valid_reg)
                    begin
                        out_stamp_next = (held_kind_reg == KIND_NORMAL) ? held_stamp_reg : '0;
                        out_kind_next  = held_kind_reg;
                    end
                    else
                    begin
                        out_stamp_next = '0;
                        out_kind_next  = KIND_NAT;
                    end
                    held_stamp_next = '0;
                    held_kind_next  = KIND_NORMAL;
                    held_valid_next = 1'b0;
                    count_next      = '0;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            mode_reg       <= MODE_FIRST;
            held_stamp_reg <= '0;
            held_kind_reg  <= KIND_NORMAL;
            held_valid_reg <= 1'b0;
            count_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            mode_reg       <= mode_next;
            held_stamp_reg <= held_stamp_next;
            held_kind_reg  <= held_kind_next;
            held_valid_reg <= held_valid_next;
            count_reg      <= count_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pt_stamp_reg  <= pt_stamp_next;
        pt_kind_reg   <= pt_kind_next;
        pt_last_reg   <= pt_last_next;
        q_reg         <= q_next;
        carry_reg     <= carry_next;
        add_cnt_reg   <= add_cnt_next;
        out_stamp_reg <= out_stamp_next;
        out_kind_reg  <= out_kind_next;
    end

endmodule

>>> dv/tb.sv
// Self-checking testbench for the block timestamp aggregator core.
`timescale 1ns / 1ps

module tb;
    import tsagg_pkg::*;

    localparam int SETTLE    = 400;      // quiet cycles before a mode write
    localparam int HOLD_OFF  = 3000;     // long receiver stall
    localparam int LIMIT     = 1500000;
    localparam int N_RANDOM  = 950;

    typedef struct {
        bit                   is_cfg;
        logic [MODE_BITS-1:0] mode;
        stamp_t               stamp;
        kind_t                kind;
        logic                 fin;
        int                   gap;
    } feed_t;

    typedef struct {
        stamp_t stamp;
        kind_t  kind;
    } blk_t;

    logic clk = 1'b0;
    logic rst_n;

    tsagg_point_if points();
    tsagg_block_if blocks();
    tsagg_cfg_if   cfg();

    block_timestamp_aggregator_core uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .points (points),
        .blocks (blocks),
        .cfg    (cfg)
    );

    feed_t work_q[$];
    blk_t  due_blocks[$];

    // running block value as the block should hold it
    logic [MODE_BITS-1:0]  cur_mode = MODE_FIRST;
    stamp_t                acc_stamp = '0;
    kind_t                 acc_kind = KIND_NORMAL;
    logic                  acc_valid = 1'b0;
    logic [COUNT_BITS-1:0] acc_count = '0;

    int     n_err = 0;
    int     n_pts = 0;
    int     n_cfg = 0;
    int     n_blocks = 0;
    int     n_items = 0;
    int     cycles = 0;
    int     hold_left = 0;
    bit     held_off = 0;
    int     feed_gap = 0;
    int     quiet = 0;
    int     rx_wait = 0;
    int     cur_stall = 0;
    int     max_stall = 0;
    bit     calm = 0;
    stamp_t base_stamp = '0;

    task automatic report(input string msg);
        n_err++;
        $display("mismatch @%0t: %s", $realtime, msg);
    endtask

    //------------------------------------------------------------------
    // prediction

    task automatic hold_value(input stamp_t s, input kind_t k);
        acc_stamp = (k == KIND_NORMAL) ? s : '0;
        acc_kind  = k;
        acc_valid = 1'b1;
    endtask

    function automatic logic [1:0] order_of(input kind_t k);
        return (k == KIND_NINF) ? 2'd0 : (k == KIND_PINF) ? 2'd2 : 2'd1;
    endfunction

    function automatic bit earlier(input stamp_t sa, input kind_t ka,
                                   input stamp_t sb, input kind_t kb);
        if (order_of(ka) != order_of(kb))
            return order_of(ka) < order_of(kb);
        return (ka == KIND_NORMAL) && (sa < sb);
    endfunction

    // h + (s - h) / div, quotient truncated toward zero
    function automatic stamp_t step_toward(input stamp_t s, input stamp_t h,
                                           input longint div);
        longint d;
        d = longint'({2'b00, s}) - longint'({2'b00, h});
        return stamp_t'(longint'({2'b00, h}) + d / div);
    endfunction

    task automatic keep_extreme(input stamp_t s, input kind_t k, input bit want_max);
        if (!acc_valid)
            hold_value(s, k);
        if (acc_kind == KIND_NAT)
            return;
        if (k == KIND_NAT)
        begin
            hold_value('0, KIND_NAT);
            return;
        end
        if (want_max ? earlier(acc_stamp, acc_kind, s, k) : earlier(s, k, acc_stamp, acc_kind))
            hold_value(s, k);
    endtask

    task automatic fold_point(input stamp_t s, input kind_t k, input logic fin);
        blk_t res;
        case (cur_mode)
            MODE_LAST:
                if (fin)
                    hold_value(s, k);
            MODE_MAX:
                keep_extreme(s, k, 1'b1);
            MODE_MEAN:
                // special stamps skipped; a held special stays as it is
                if (k == KIND_NORMAL && !(acc_valid && acc_kind != KIND_NORMAL))
                begin
                    if (acc_valid)
                    begin
                        if (acc_count != '1)
                            acc_count++;
                        acc_stamp = step_toward(s, acc_stamp, longint'({32'b0, acc_count}));
                    end
                    else
                    begin
                        acc_count = COUNT_BITS'(1);
                        hold_value(s, k);
                    end
                end
            MODE_MIDDLE:
            begin
                if (!acc_valid)
                    hold_value(s, k);
                if (fin)
                begin
                    if (k != KIND_NORMAL || acc_kind != KIND_NORMAL)
                        hold_value('0, KIND_NAT);
                    else
                        acc_stamp = step_toward(s, acc_stamp, longint'({32'b0, MID_DIVISOR}));
                end
            end
            MODE_MIN:
                keep_extreme(s, k, 1'b0);
            default:
                if (!acc_valid)
                    hold_value(s, k);
        endcase
        if (fin)
        begin
            if (acc_valid)
            begin
                res.stamp = (acc_kind == KIND_NORMAL) ? acc_stamp : '0;
                res.kind  = acc_kind;
            end
            else
            begin
                res.stamp = '0;
                res.kind  = KIND_NAT;
            end
            due_blocks.insert(due_blocks.size(), res);
            acc_stamp = '0;
            acc_kind  = KIND_NORMAL;
            acc_valid = 1'b0;
            acc_count = '0;
        end
    endtask

    //------------------------------------------------------------------
    // stimulus building

    task automatic add_point(input stamp_t s, input kind_t k, input logic fin);
        feed_t it;
        it.is_cfg = 1'b0;
        it.mode   = '0;
        it.stamp  = s;
        it.kind   = k;
        it.fin    = fin;
        it.gap    = calm ? 0 : $urandom_range(0, 10);
        work_q.insert(work_q.size(), it);
        n_items++;
    endtask

    task automatic add_mode(input logic [MODE_BITS-1:0] m);
        feed_t it;
        it.is_cfg = 1'b1;
        it.mode   = m;
        it.stamp  = '0;
        it.kind   = KIND_NORMAL;
        it.fin    = 1'b0;
        it.gap    = calm ? 0 : $urandom_range(0, 10);
        work_q.insert(work_q.size(), it);
    endtask

    function automatic stamp_t rand_stamp();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2, 3, 4: return base_stamp + stamp_t'($urandom_range(0, 4000)) - stamp_t'(2000);
            default: return stamp_t'({$urandom, $urandom});
        endcase
    endfunction

    function automatic kind_t rand_kind();
        case ($urandom_range(0, 15))
            0:       return KIND_NAT;
            1:       return KIND_PINF;
            2:       return KIND_NINF;
            default: return KIND_NORMAL;
        endcase
    endfunction

    task automatic add_block(input int len);
        for (int i = 0; i < len; i++)
            add_point(rand_stamp(), rand_kind(), i == len - 1);
    endtask

    //------------------------------------------------------------------
    // clock

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    //------------------------------------------------------------------
    // point and mode-write driver

    always @(posedge clk)
    begin
        feed_t it;
        logic  nxt_pv;
        logic  nxt_cv;
        if (!rst_n)
        begin
            points.valid         <= 1'b0;
            points.stamp         <= '0;
            points.stamp_kind    <= KIND_NORMAL;
            points.last_of_block <= 1'b0;
            cfg.valid            <= 1'b0;
            cfg.data             <= '0;
            feed_gap = 0;
            quiet    = 0;
        end
        else
        begin
            nxt_pv = points.valid && !points.ready;
            nxt_cv = cfg.valid && !cfg.ready;
            if (points.valid && points.ready)
            begin
                fold_point(points.stamp, kind_t'(points.stamp_kind), points.last_of_block);
                n_pts++;
            end
            if (cfg.valid && cfg.ready)
            begin
                cur_mode = cfg.data;
                n_cfg++;
            end
            if (points.valid && !points.ready)
            begin
                cur_stall++;
                if (cur_stall > max_stall)
                    max_stall = cur_stall;
            end
            else
                cur_stall = 0;
            if ((points.valid && points.ready) || (blocks.valid && blocks.ready))
                quiet = 0;
            else if (quiet < SETTLE)
                quiet++;

            if (!nxt_pv && !nxt_cv && work_q.size() != 0)
            begin
                if (feed_gap > 0)
                    feed_gap--;
                else if (!work_q[0].is_cfg)
                begin
                    it = work_q.pop_front();
                    points.stamp         <= it.stamp;
                    points.stamp_kind    <= it.kind;
                    points.last_of_block <= it.fin;
                    nxt_pv   = 1'b1;
                    feed_gap = it.gap;
                end
                else if (due_blocks.size() == 0 && quiet >= SETTLE)
                begin
                    // mode only changes once the core has gone quiet
                    it = work_q.pop_front();
                    cfg.data <= it.mode;
                    nxt_cv   = 1'b1;
                    feed_gap = it.gap;
                end
            end
            points.valid <= nxt_pv;
            cfg.valid    <= nxt_cv;
        end
    end

    //------------------------------------------------------------------
    // block monitor and receiver

    always @(posedge clk)
    begin
        blk_t want;
        if (!rst_n)
        begin
            blocks.ready <= 1'b0;
            rx_wait = 0;
        end
        else
        begin
            if (blocks.valid && blocks.ready)
            begin
                n_blocks <= n_blocks + 1;
                if (due_blocks.size() == 0)
                    report($sformatf("unexpected block: stamp %h kind %0d",
                                     blocks.block_stamp, blocks.block_kind));
                else
                begin
                    want = due_blocks.pop_front();
                    if (blocks.block_kind !== want.kind)
                        report($sformatf("block %0d kind %0d, want %0d",
                                         n_blocks, blocks.block_kind, want.kind));
                    if (blocks.block_stamp !== want.stamp)
                        report($sformatf("block %0d stamp %h, want %h",
                                         n_blocks, blocks.block_stamp, want.stamp));
                end
                // every third stretch of 25 blocks takes them back to back
                rx_wait = ((n_blocks / 25) % 3 == 1) ? 0 : $urandom_range(0, 10);
            end
            else if (rx_wait > 0)
                rx_wait--;
            blocks.ready <= (rx_wait == 0) && (hold_left == 0);
        end
    end

    // one long receiver hold-off so the core backs up into its input
    always @(posedge clk)
    begin
        if (!rst_n)
            hold_left <= 0;
        else if (n_blocks == 40 && !held_off)
        begin
            hold_left <= HOLD_OFF;
            held_off  <= 1'b1;
        end
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == LIMIT)
        begin
            $display("tb NOT OK");
            $finish;
        end
    end

    //------------------------------------------------------------------
    // test sequence

    initial
    begin
        int phase;
        int target;
        int start;
        rst_n = 1'b0;

        // directed: reset mode is first
        add_point('0, KIND_NORMAL, 1'b0);
        add_point('1, KIND_NORMAL, 1'b1);
        add_point(stamp_t'(77), KIND_NAT, 1'b1);
        add_mode(MODE_MAX);
        add_point('1, KIND_NINF, 1'b0);
        add_point('1, KIND_NORMAL, 1'b0);
        add_point('0, KIND_PINF, 1'b0);
        add_point(stamp_t'(5), KIND_NORMAL, 1'b1);
        add_point(stamp_t'(3), KIND_NORMAL, 1'b0);
        add_point('1, KIND_NAT, 1'b0);
        add_point('0, KIND_PINF, 1'b1);
        add_mode(MODE_MIN);
        add_point('0, KIND_PINF, 1'b0);
        add_point('0, KIND_NORMAL, 1'b0);
        add_point('1, KIND_NINF, 1'b1);
        add_mode(MODE_MEAN);
        add_point('0, KIND_NAT, 1'b0);
        add_point('1, KIND_NORMAL, 1'b0);
        add_point('0, KIND_NORMAL, 1'b0);
        add_point('1, KIND_PINF, 1'b1);
        add_point('0, KIND_NINF, 1'b1);          // mean with nothing usable
        add_mode(MODE_MIDDLE);
        add_point(stamp_t'(10), KIND_NORMAL, 1'b0);
        add_point(stamp_t'(3), KIND_NORMAL, 1'b1); // negative half-step
        add_point('0, KIND_PINF, 1'b0);
        add_point(stamp_t'(5), KIND_NORMAL, 1'b1);
        add_mode(MODE_LAST);
        add_point(stamp_t'(1), KIND_NORMAL, 1'b0);
        add_point(stamp_t'(2), KIND_NORMAL, 1'b1);
        add_mode(3'd7);                          // undefined code acts as first
        add_point('0, KIND_NINF, 1'b0);
        add_point(stamp_t'(9), KIND_NORMAL, 1'b1);

        // random phases, one mode each; some leave a block open across the write
        start = n_items;
        phase = 0;
        while (n_items - start < N_RANDOM)
        begin
            calm       = ($urandom_range(0, 3) == 0);
            base_stamp = stamp_t'({$urandom, $urandom});
            add_mode((phase < 8) ? phase[MODE_BITS-1:0] : MODE_BITS'($urandom_range(0, 7)));
            target = n_items + $urandom_range(40, 90);
            while (n_items < target)
                add_block(($urandom_range(0, 7) == 0) ? $urandom_range(9, 24)
                                                      : $urandom_range(1, 6));
            if ($urandom_range(0, 2) == 0)
                repeat ($urandom_range(1, 3))
                    add_point(rand_stamp(), rand_kind(), 1'b0);
            phase++;
        end
        calm = 1'b0;
        add_mode(MODE_FIRST);
        add_block(2);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        do
            @(posedge clk);
        while (work_q.size() != 0 || points.valid || cfg.valid || due_blocks.size() != 0);
        repeat (SETTLE) @(posedge clk);

        if (due_blocks.size() != 0)
            report($sformatf("%0d blocks never came out", due_blocks.size()));
        $display("run: %0d points, %0d blocks checked, %0d mode writes (codes 0-7)",
                 n_pts, n_blocks, n_cfg);
        $display("run: longest input back-pressure %0d cycles, %0d mismatches",
                 max_stall, n_err);
        if (n_err == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule

>>> block_timestamp_aggregator_core.f
design/tsagg_pkg.sv
design/tsagg_if.sv
design/tsagg_diff.sv
design/tsagg_div.sv
design/block_timestamp_aggregator_core.sv
dv/tb.sv
